@@ rtl/mts_pkg.sv @@
`default_nettype none

package mts_pkg;

    // Default sizes
    localparam int unsigned TEXT_DEPTH_DEF = 64;
    localparam int unsigned WINDOW_MAX_DEF = 32;

    // Field widths
    localparam int unsigned ACTION_W   = 2;
    localparam int unsigned INDEX_W    = 6;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned POSN_W     = 5;
    localparam int unsigned TLEN_W     = 7;
    localparam int unsigned WLEN_W     = 6;
    localparam int unsigned OFF_W      = 7;
    localparam int unsigned PCNT_W     = 6;
    localparam int unsigned CALC_W     = 8;
    localparam int unsigned CFG_AW     = 1;
    localparam int unsigned CFG_DW     = 7;
    localparam int unsigned S_TDATA_W  = 16;
    localparam int unsigned M_TDATA_W  = 16;

    localparam logic [CHAR_W-1:0] SPACE_CHAR  = 8'h20;
    localparam logic [WLEN_W-1:0] WIN_LEN_RST = 6'd16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_RESTART = 2'd1,
        ACT_TICK    = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_ADD  = 2'd1,
        PH_COOL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SW_FILL  = 2'd0,
        SW_SHIFT = 2'd1,
        SW_HOLD  = 2'd2
    } t_sweep;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MOD   = 3'd1,
        ST_FETCH = 3'd2,
        ST_GRAB  = 3'd3,
        ST_SWEEP = 3'd4
    } t_ctl_state;

    typedef enum logic [CFG_AW-1:0] {
        CFG_TEXT_LEN = 1'b0,
        CFG_WIN_LEN  = 1'b1
    } t_cfg_reg;

    // Controller to datapath
    typedef struct packed {
        logic   load;
        logic   calc;
        logic   mod_start;
        logic   fetch;
        logic   grab;
        logic   sweep_start;
        t_sweep sweep_mode;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic win_zero;
        logic scrolls;
        logic need_text;
        logic mod_done;
        logic sweep_done;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ rtl/mts_ctrl.sv @@
`default_nettype none

module mts_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_valid,
    input  wire logic [mts_pkg::ACTION_W-1:0]   i_action,
    output logic                                o_s_ready,
    input  wire mts_pkg::t_dp_stat              i_stat,
    output mts_pkg::t_dp_cmd                    o_cmd
);

    mts_pkg::t_ctl_state r_state;
    mts_pkg::t_ctl_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            mts_pkg::ST_IDLE: begin
                o_s_ready = 1'b1;
                if (i_s_valid) begin
                    case (mts_pkg::t_action'(i_action))
                        mts_pkg::ACT_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        mts_pkg::ACT_RESTART: begin
                            o_cmd.sweep_start = 1'b1;
                            o_cmd.sweep_mode  = mts_pkg::SW_FILL;
                            n_state           = mts_pkg::ST_SWEEP;
                        end
                        mts_pkg::ACT_TICK: begin
                            if (!i_stat.win_zero) begin
                                if (i_stat.scrolls) begin
                                    o_cmd.calc = 1'b1;
                                    if (i_stat.need_text) begin
                                        o_cmd.mod_start = 1'b1;
                                        n_state         = mts_pkg::ST_MOD;
                                    end else begin
                                        o_cmd.sweep_start = 1'b1;
                                        o_cmd.sweep_mode  = mts_pkg::SW_SHIFT;
                                        n_state           = mts_pkg::ST_SWEEP;
                                    end
                                end else begin
                                    o_cmd.sweep_start = 1'b1;
                                    o_cmd.sweep_mode  = mts_pkg::SW_HOLD;
                                    n_state           = mts_pkg::ST_SWEEP;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mts_pkg::ST_MOD: begin
                if (i_stat.mod_done) begin
                    n_state = mts_pkg::ST_FETCH;
                end
            end
            mts_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = mts_pkg::ST_GRAB;
            end
            mts_pkg::ST_GRAB: begin
                o_cmd.grab        = 1'b1;
                o_cmd.sweep_start = 1'b1;
                o_cmd.sweep_mode  = mts_pkg::SW_SHIFT;
                n_state           = mts_pkg::ST_SWEEP;
            end
            mts_pkg::ST_SWEEP: begin
                if (i_stat.sweep_done) begin
                    n_state = mts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/mts_datapath.sv @@
`default_nettype none

module mts_datapath #(
    parameter int unsigned TEXT_DEPTH = mts_pkg::TEXT_DEPTH_DEF,
    parameter int unsigned WINDOW_MAX = mts_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [mts_pkg::CFG_AW-1:0]     i_cfg_addr,
    input  wire logic [mts_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  wire logic [mts_pkg::INDEX_W-1:0]    i_char_index,
    input  wire logic [mts_pkg::CHAR_W-1:0]     i_char_value,
    input  wire mts_pkg::t_dp_cmd               i_cmd,
    output mts_pkg::t_dp_stat                   o_stat,
    input  wire logic                           i_m_ready,
    output logic                                o_m_valid,
    output logic [mts_pkg::POSN_W-1:0]          o_position,
    output logic [mts_pkg::CHAR_W-1:0]          o_character,
    output logic                                o_last
);

    localparam int unsigned TEXT_AW  = $clog2(TEXT_DEPTH);
    localparam int unsigned WIN_AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned WIN_CW   = $clog2(WINDOW_MAX + 1);
    localparam int unsigned TEXT_CAP = (TEXT_DEPTH < 127) ? TEXT_DEPTH : 127;
    localparam int unsigned WIN_CAP  = (WINDOW_MAX < 63) ? WINDOW_MAX : 63;
    localparam int unsigned MOD_CW   = $clog2(mts_pkg::CALC_W);

    localparam logic [mts_pkg::TLEN_W-1:0] TEXT_CAP_V = mts_pkg::TLEN_W'(TEXT_CAP);
    localparam logic [mts_pkg::WLEN_W-1:0] WIN_CAP_V  = mts_pkg::WLEN_W'(WIN_CAP);
    localparam logic [WIN_CW-1:0]          FILL_END   = WIN_CW'(WINDOW_MAX);
    localparam logic [MOD_CW-1:0]          MOD_LAST   = MOD_CW'(mts_pkg::CALC_W - 1);

    // Configuration registers
    logic [mts_pkg::TLEN_W-1:0] r_text_len;
    logic [mts_pkg::WLEN_W-1:0] r_win_len;

    // Scroll state
    logic [mts_pkg::OFF_W-1:0]  r_off,   n_off;
    logic [mts_pkg::PCNT_W-1:0] r_pcnt,  n_pcnt;
    mts_pkg::t_phase            r_phase, n_phase;
    logic [mts_pkg::CHAR_W-1:0] r_enter;

    // Remainder unit
    logic [mts_pkg::CALC_W-1:0] r_mod_num;
    logic [mts_pkg::TLEN_W-1:0] r_rem;
    logic [MOD_CW-1:0]          r_mod_cnt;
    logic                       r_mod_busy;

    // Memories
    logic [mts_pkg::CHAR_W-1:0] r_text_mem [TEXT_DEPTH];
    logic [mts_pkg::CHAR_W-1:0] r_text_q;
    logic [mts_pkg::CHAR_W-1:0] r_win_mem [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]      r_win_vld;
    logic [mts_pkg::CHAR_W-1:0] r_win_q;
    logic                       r_win_qv;

    // Sweep engine
    logic                       r_active;
    mts_pkg::t_sweep            r_mode;
    logic [WIN_CW-1:0]          r_rd_idx;
    logic [WIN_CW-1:0]          r_wr_idx;
    logic [WIN_CW-1:0]          r_end;
    logic                       r_dv;
    logic                       r_in_text;

    // Output register
    logic                       r_out_valid;
    logic [mts_pkg::POSN_W-1:0] r_out_pos;
    logic [mts_pkg::CHAR_W-1:0] r_out_char;
    logic                       r_out_last;

    logic [mts_pkg::TLEN_W-1:0] len;
    logic [mts_pkg::WLEN_W-1:0] win;
    logic [mts_pkg::CALC_W-1:0] len8;
    logic [mts_pkg::CALC_W-1:0] win8;
    logic [mts_pkg::OFF_W-1:0]  off_inc;
    logic [mts_pkg::OFF_W-1:0]  off_tmp;
    logic [mts_pkg::PCNT_W-1:0] pcnt_inc;
    logic [mts_pkg::CALC_W-1:0] pos_c;
    logic [mts_pkg::CALC_W-1:0] mod_t;
    logic [mts_pkg::TLEN_W-1:0] mod_nrem;
    logic                       mod_done;
    logic [mts_pkg::CALC_W-1:0] load_a8;
    logic [mts_pkg::CALC_W-1:0] rd_idx8;
    logic [mts_pkg::CALC_W-1:0] wr_idx8;
    logic [mts_pkg::CALC_W-1:0] text_rd_a8;
    logic                       text_rd_en;
    logic [WIN_CW-1:0]          nxt_idx;
    logic [WIN_CW-1:0]          win_rd_idx;
    logic                       win_rd_en;
    logic                       emit_cur;
    logic                       out_free;
    logic                       consume;
    logic                       issue;
    logic                       sweep_done;
    logic                       wr_last;
    logic [mts_pkg::CHAR_W-1:0] wr_val;

    // Effective lengths
    assign len  = (r_text_len > TEXT_CAP_V) ? TEXT_CAP_V : r_text_len;
    assign win  = (r_win_len > WIN_CAP_V) ? WIN_CAP_V : r_win_len;
    assign len8 = mts_pkg::CALC_W'(len);
    assign win8 = mts_pkg::CALC_W'(win);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_len <= '0;
            r_win_len  <= mts_pkg::WIN_LEN_RST;
        end else if (i_cfg_we) begin
            case (mts_pkg::t_cfg_reg'(i_cfg_addr))
                mts_pkg::CFG_TEXT_LEN: r_text_len <= i_cfg_wdata;
                mts_pkg::CFG_WIN_LEN:  r_win_len  <= i_cfg_wdata[mts_pkg::WLEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scroll step: offset, padding count and phase for one tick, cleared on a restart
    assign off_inc  = r_off + 7'd1;
    assign pcnt_inc = r_pcnt + 6'd1;
    assign pos_c    = win8 - 8'd1 + mts_pkg::CALC_W'(off_inc);

    always_comb begin
        n_off   = r_off;
        n_pcnt  = r_pcnt;
        n_phase = r_phase;
        off_tmp = off_inc;
        if (i_cmd.sweep_start && (i_cmd.sweep_mode == mts_pkg::SW_FILL)) begin
            n_off   = '0;
            n_pcnt  = '0;
            n_phase = mts_pkg::PH_WAIT;
        end else if (i_cmd.calc) begin
            if (r_phase == mts_pkg::PH_ADD) begin
                n_pcnt = pcnt_inc;
                if (pcnt_inc >= win) begin
                    off_tmp = off_inc - mts_pkg::OFF_W'(pcnt_inc);
                    n_pcnt  = '0;
                    n_phase = mts_pkg::PH_COOL;
                end
            end else if (r_phase == mts_pkg::PH_COOL) begin
                n_phase = mts_pkg::PH_WAIT;
            end else if (pos_c == (len8 - 8'd1)) begin
                n_phase = mts_pkg::PH_ADD;
            end
            n_off = (off_tmp == len) ? '0 : off_tmp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off   <= '0;
            r_pcnt  <= '0;
            r_phase <= mts_pkg::PH_WAIT;
        end else begin
            r_off   <= n_off;
            r_pcnt  <= n_pcnt;
            r_phase <= n_phase;
        end
    end

    // Entering character: space while padding, else fetched text
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_enter <= mts_pkg::SPACE_CHAR;
        end else if (i_cmd.grab) begin
            r_enter <= r_text_q;
        end
    end

    // Restoring remainder, one bit of the position a cycle
    assign mod_t    = {r_rem, r_mod_num[mts_pkg::CALC_W-1]};
    assign mod_nrem = (mod_t >= len8) ? mts_pkg::TLEN_W'(mod_t - len8)
                                      : mod_t[mts_pkg::TLEN_W-1:0];
    assign mod_done = r_mod_busy && (r_mod_cnt == MOD_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_busy <= 1'b0;
            r_mod_cnt  <= '0;
        end else if (i_cmd.mod_start) begin
            r_mod_busy <= 1'b1;
            r_mod_cnt  <= '0;
        end else if (r_mod_busy) begin
            r_mod_cnt <= r_mod_cnt + 1'b1;
            if (r_mod_cnt == MOD_LAST) begin
                r_mod_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mod_start) begin
            r_mod_num <= pos_c;
            r_rem     <= '0;
        end else if (r_mod_busy) begin
            r_mod_num <= {r_mod_num[mts_pkg::CALC_W-2:0], 1'b0};
            r_rem     <= mod_nrem;
        end
    end

    // Sweep control
    assign rd_idx8   = mts_pkg::CALC_W'(r_rd_idx);
    assign wr_idx8   = mts_pkg::CALC_W'(r_wr_idx);
    assign emit_cur  = (r_mode != mts_pkg::SW_FILL) || (wr_idx8 < win8);
    assign out_free  = !r_out_valid || i_m_ready;
    assign consume   = r_dv && (out_free || !emit_cur);
    assign issue     = r_active && (r_rd_idx != r_end) && (!r_dv || consume);
    assign sweep_done = r_active && (r_rd_idx == r_end) && (!r_dv || consume);
    assign wr_last   = (wr_idx8 + 8'd1) == win8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_dv     <= 1'b0;
            r_mode   <= mts_pkg::SW_HOLD;
            r_rd_idx <= '0;
            r_wr_idx <= '0;
            r_end    <= '0;
        end else if (i_cmd.sweep_start) begin
            r_active <= 1'b1;
            r_dv     <= 1'b0;
            r_mode   <= i_cmd.sweep_mode;
            r_rd_idx <= '0;
            r_end    <= (i_cmd.sweep_mode == mts_pkg::SW_FILL) ? FILL_END : WIN_CW'(win);
        end else begin
            if (issue) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_wr_idx <= r_rd_idx;
                r_dv     <= 1'b1;
            end else if (consume) begin
                r_dv <= 1'b0;
            end
            if (sweep_done) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_in_text <= rd_idx8 < len8;
        end
    end

    // Text memory: load writes, fill and fetch read
    assign load_a8    = mts_pkg::CALC_W'(i_char_index);
    assign text_rd_en = i_cmd.fetch || (issue && (r_mode == mts_pkg::SW_FILL));
    assign text_rd_a8 = i_cmd.fetch ? mts_pkg::CALC_W'(r_rem) : rd_idx8;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(load_a8) < TEXT_DEPTH)) begin
            r_text_mem[load_a8[TEXT_AW-1:0]] <= i_char_value;
        end
        if (text_rd_en) begin
            r_text_q <= r_text_mem[text_rd_a8[TEXT_AW-1:0]];
        end
    end

    // Window memory: a shift reads one place to the right
    assign nxt_idx    = r_rd_idx + 1'b1;
    assign win_rd_idx = ((r_mode == mts_pkg::SW_SHIFT) && (32'(nxt_idx) < WINDOW_MAX))
                        ? nxt_idx : r_rd_idx;
    assign win_rd_en  = issue && (r_mode != mts_pkg::SW_FILL);

    always_comb begin
        case (r_mode)
            mts_pkg::SW_FILL:  wr_val = r_in_text ? r_text_q : '0;
            mts_pkg::SW_SHIFT: wr_val = wr_last ? r_enter : (r_win_qv ? r_win_q : '0);
            default:           wr_val = r_win_qv ? r_win_q : '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (consume && (r_mode != mts_pkg::SW_HOLD)) begin
            r_win_mem[r_wr_idx[WIN_AW-1:0]] <= wr_val;
        end
        if (win_rd_en) begin
            r_win_q  <= r_win_mem[win_rd_idx[WIN_AW-1:0]];
            r_win_qv <= r_win_vld[win_rd_idx[WIN_AW-1:0]];
        end
    end

    // Entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_vld <= '0;
        end else if (consume && (r_mode != mts_pkg::SW_HOLD)) begin
            r_win_vld[r_wr_idx[WIN_AW-1:0]] <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && emit_cur) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && emit_cur) begin
            r_out_pos  <= wr_idx8[mts_pkg::POSN_W-1:0];
            r_out_char <= wr_val;
            r_out_last <= wr_last;
        end
    end

    assign o_m_valid   = r_out_valid;
    assign o_position  = r_out_pos;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    assign o_stat.win_zero   = (win == '0);
    assign o_stat.scrolls    = len > mts_pkg::TLEN_W'(win);
    assign o_stat.need_text  = (r_phase != mts_pkg::PH_ADD);
    assign o_stat.mod_done   = mod_done;
    assign o_stat.sweep_done = sweep_done;

    // Checks
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod_busy |-> (mts_pkg::CALC_W'(r_rem) < len8))
        else $error("remainder not below text length");

    a_rd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_rd_idx <= r_end))
        else $error("sweep read index past end");

    a_wr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && r_dv) |-> (r_wr_idx < r_end))
        else $error("sweep write index past end");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (consume && emit_cur) |=> r_out_valid)
        else $error("emitted word lost");

endmodule

`default_nettype wire

@@ rtl/marquee_text_scroller.sv @@
`default_nettype none

// Marquee window over a stored text line. Words on the input stream load one
// text character, restart the scroll or advance it by one tick; restarts and
// ticks send the whole window out, one character per word, with tlast on the
// rightmost position. A tick on a text that fits the window or one that brings
// in a padding space goes straight to the sweep; a tick that brings in a text
// character first has an 8-step remainder unit find the text position entering
// at the right; a read and a capture follow, then the window memory moves one
// entry per cycle while the output is not stalled. Output back-pressure holds
// the sweep. The user must make configuration writes only while the block is
// idle; the block itself does not enforce this.
module marquee_text_scroller #(
    parameter int unsigned TEXT_DEPTH = mts_pkg::TEXT_DEPTH_DEF,
    parameter int unsigned WINDOW_MAX = mts_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input words
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [5:0] char_index, [13:6] char_value, [15:14] zero
    input  wire logic [mts_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  wire logic [mts_pkg::ACTION_W-1:0]    s_axis_tuser,
    // Result words
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [4:0] position, [12:5] character, [15:13] zero
    output logic [mts_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    output logic                                 m_axis_tlast,
    // Register writes
    input  wire logic                            i_cfg_we,
    input  wire logic [mts_pkg::CFG_AW-1:0]      i_cfg_addr,
    input  wire logic [mts_pkg::CFG_DW-1:0]      i_cfg_wdata
);

    mts_pkg::t_dp_cmd            cmd;
    mts_pkg::t_dp_stat           stat;
    logic [mts_pkg::POSN_W-1:0]  position;
    logic [mts_pkg::CHAR_W-1:0]  character;

    mts_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_action  (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    mts_datapath #(
        .TEXT_DEPTH (TEXT_DEPTH),
        .WINDOW_MAX (WINDOW_MAX)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_char_index (s_axis_tdata[mts_pkg::INDEX_W-1:0]),
        .i_char_value (s_axis_tdata[mts_pkg::INDEX_W+mts_pkg::CHAR_W-1:mts_pkg::INDEX_W]),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_position   (position),
        .o_character  (character),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = mts_pkg::M_TDATA_W'({character, position});

endmodule

`default_nettype wire
